/* src/ddd_pkg.sv */
// ----------------------------------------------------------------------------
// ddd_pkg
// Shared widths, constants and tables for the date day difference core.
// ----------------------------------------------------------------------------
package ddd_pkg;

  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_W      = 14;
  localparam int DAYNUM_W    = 23;
  localparam int DAY_COUNT_W = 22;
  localparam int CODE_W      = 2;
  localparam int LCOUNT_W    = 13;

  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 24;

  // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT, exact for x < 4096
  localparam int RECIP_25    = 10486;
  localparam int RECIP_SHIFT = 18;
  localparam int Q4_W        = YEAR_W - 2;
  localparam int Q16_W       = YEAR_W - 4;
  localparam int P100_W      = Q4_W + 14;
  localparam int P400_W      = Q16_W + 14;
  localparam int Q100_W      = P100_W - RECIP_SHIFT;
  localparam int Q400_W      = P400_W - RECIP_SHIFT;

  localparam int DAYS_YEAR   = 365;

  localparam logic [DAY_COUNT_W-1:0] DAY_COUNT_MAX = {DAY_COUNT_W{1'b1}};

  localparam logic [CODE_W-1:0] ORDER_EQUAL   = 2'd0;
  localparam logic [CODE_W-1:0] ORDER_LATER   = 2'd1;
  localparam logic [CODE_W-1:0] ORDER_EARLIER = 2'd2;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } ddd_adv_t;

  // days before month m in a common year; months past December run 30 days
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      4'd13:   r = 9'd365;
      4'd14:   r = 9'd395;
      4'd15:   r = 9'd425;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* src/ddd_date_num.sv */
// ----------------------------------------------------------------------------
// ddd_date_num
// Three-stage day number of one date: products, quotients, final sum.
// ----------------------------------------------------------------------------
module ddd_date_num import ddd_pkg::*; (
  input  logic                clk,
  input  ddd_adv_t            adv,
  input  logic [DAY_W-1:0]    day,
  input  logic [MONTH_W-1:0]  month,
  input  logic [YEAR_W-1:0]   year,
  output logic [DAYNUM_W-1:0] day_num
);

  // stage 1
  logic [YEAR_W-1:0]   y1;
  logic                ypos1;
  logic [Q4_W-1:0]     pq4_1;
  logic [P100_W-1:0]   py100_1;
  logic [P400_W-1:0]   py400_1;
  logic [P100_W-1:0]   pp100_1;
  logic [P400_W-1:0]   pp400_1;
  logic [DAYNUM_W-1:0] y365_1;
  logic [8:0]          dbm1;
  logic                mhi1;
  logic [DAY_W-1:0]    d1;

  // stage 2
  logic [DAYNUM_W-1:0] base2;
  logic [LCOUNT_W-1:0] lcount2;
  logic                adj2;

  logic [YEAR_W-1:0]   p;
  logic [Q100_W-1:0]   qy100, qp100;
  logic [Q400_W-1:0]   qy400, qp400;
  logic                div4, div100, div400, leap;
  logic [LCOUNT_W-1:0] lcount;

  assign p = year - YEAR_W'(1);

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      y1      <= year;
      ypos1   <= (year != '0);
      pq4_1   <= p[YEAR_W-1:2];
      py100_1 <= P100_W'(year[YEAR_W-1:2]) * P100_W'(RECIP_25);
      py400_1 <= P400_W'(year[YEAR_W-1:4]) * P400_W'(RECIP_25);
      pp100_1 <= P100_W'(p[YEAR_W-1:2]) * P100_W'(RECIP_25);
      pp400_1 <= P400_W'(p[YEAR_W-1:4]) * P400_W'(RECIP_25);
      y365_1  <= DAYNUM_W'(year) * DAYNUM_W'(DAYS_YEAR);
      dbm1    <= days_before(month);
      mhi1    <= (month > MONTH_W'(2));
      d1      <= day;
    end
  end

  assign qy100 = py100_1[P100_W-1:RECIP_SHIFT];
  assign qp100 = pp100_1[P100_W-1:RECIP_SHIFT];
  assign qy400 = py400_1[P400_W-1:RECIP_SHIFT];
  assign qp400 = pp400_1[P400_W-1:RECIP_SHIFT];

  assign div4   = (y1[1:0] == 2'b00);
  assign div100 = div4 && ((Q4_W'(qy100) * Q4_W'(25)) == y1[YEAR_W-1:2]);
  assign div400 = (y1[3:0] == 4'b0000) && ((Q16_W'(qy400) * Q16_W'(25)) == y1[YEAR_W-1:4]);
  assign leap   = div4 && (!div100 || div400);

  // leap years in 0..y-1, year 0 included
  assign lcount = ypos1 ? (LCOUNT_W'(pq4_1) - LCOUNT_W'(qp100) + LCOUNT_W'(qp400)
                           + LCOUNT_W'(1)) : '0;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      base2   <= y365_1 + DAYNUM_W'(dbm1) + DAYNUM_W'(d1);
      lcount2 <= lcount;
      adj2    <= leap && mhi1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      day_num <= base2 + DAYNUM_W'(lcount2) + DAYNUM_W'(adj2);
    end
  end

endmodule

/* src/ddd_diff.sv */
// ----------------------------------------------------------------------------
// ddd_diff
// Output stage: absolute difference of two day numbers, saturated.
// ----------------------------------------------------------------------------
module ddd_diff import ddd_pkg::*; (
  input  logic                   clk,
  input  logic                   load,
  input  logic [DAYNUM_W-1:0]    num_a,
  input  logic [DAYNUM_W-1:0]    num_b,
  input  logic [CODE_W-1:0]      code_in,
  output logic [DAY_COUNT_W-1:0] day_count,
  output logic [CODE_W-1:0]      order_code
);

  logic [DAYNUM_W-1:0] diff;

  assign diff = (num_a >= num_b) ? (num_a - num_b) : (num_b - num_a);

  always_ff @(posedge clk) begin
    if (load) begin
      day_count  <= diff[DAYNUM_W-1] ? DAY_COUNT_MAX : diff[DAY_COUNT_W-1:0];
      order_code <= code_in;
    end
  end

endmodule

/* src/date_day_difference_core.sv */
// ----------------------------------------------------------------------------
// date_day_difference_core
// Days between two Gregorian dates, with the order of the two dates.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless the output stalls, set by the four-stage register pipeline.
// Each stage holds under backpressure and frees as soon as its successor does.
// Reset (rst, synchronous) clears the stage valid bits; data registers keep.
module date_day_difference_core import ddd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // first_day, first_month, first_year, second_day, second_month, second_year
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // day_count, order_code
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic [DAY_W-1:0]       first_day, second_day;
  logic [MONTH_W-1:0]     first_month, second_month;
  logic [YEAR_W-1:0]      first_year, second_year;

  logic                   v1, v2, v3, v4;
  logic                   rdy1, rdy2, rdy3, rdy4;
  ddd_adv_t               adv;

  logic [CODE_W-1:0]      code, code1, code2, code3;
  logic [DAYNUM_W-1:0]    num_a, num_b;
  logic [DAY_COUNT_W-1:0] day_count;
  logic [CODE_W-1:0]      order_code;

  assign first_day    = s_tdata[4:0];
  assign first_month  = s_tdata[8:5];
  assign first_year   = s_tdata[22:9];
  assign second_day   = s_tdata[27:23];
  assign second_month = s_tdata[31:28];
  assign second_year  = s_tdata[45:32];

  assign rdy4 = !v4 || m_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign adv.s1 = rdy1;
  assign adv.s2 = rdy2;
  assign adv.s3 = rdy3;

  assign s_tready = rdy1;
  assign m_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // order by year, month, day as plain numbers
  always_comb begin
    if ({first_year, first_month, first_day} == {second_year, second_month, second_day}) begin
      code = ORDER_EQUAL;
    end else if ({first_year, first_month, first_day} >
                 {second_year, second_month, second_day}) begin
      code = ORDER_LATER;
    end else begin
      code = ORDER_EARLIER;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) code1 <= code;
    if (rdy2) code2 <= code1;
    if (rdy3) code3 <= code2;
  end

  ddd_date_num u_num_a (
    .clk     (clk),
    .adv     (adv),
    .day     (first_day),
    .month   (first_month),
    .year    (first_year),
    .day_num (num_a)
  );

  ddd_date_num u_num_b (
    .clk     (clk),
    .adv     (adv),
    .day     (second_day),
    .month   (second_month),
    .year    (second_year),
    .day_num (num_b)
  );

  ddd_diff u_diff (
    .clk        (clk),
    .load       (rdy4),
    .num_a      (num_a),
    .num_b      (num_b),
    .code_in    (code3),
    .day_count  (day_count),
    .order_code (order_code)
  );

  assign m_tdata = {order_code, day_count};

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives date pairs into date_day_difference_core over the input stream and
// checks every output word against a day-number predictor. A directed set
// covers the field extremes, leap rules, months outside the calendar, stray
// days and saturation. Random pairs follow, with random gaps on both sides,
// one long output stall, two full drains and one back-to-back stretch.
// ----------------------------------------------------------------------------
module testbench;
  import ddd_pkg::*;

  localparam int PAD_W          = IN_DATA_W - 2 * (DAY_W + MONTH_W + YEAR_W);
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic [PAD_W-1:0]   pad;
    logic [YEAR_W-1:0]  y2;
    logic [MONTH_W-1:0] m2;
    logic [DAY_W-1:0]   d2;
    logic [YEAR_W-1:0]  y1;
    logic [MONTH_W-1:0] m1;
    logic [DAY_W-1:0]   d1;
  } date_pair_t;

  typedef struct packed {
    logic [CODE_W-1:0]      order;
    logic [DAY_COUNT_W-1:0] days;
  } span_t;

  class span_board;
    span_t       span_q[$];
    int unsigned fails;
    int unsigned checked;
    int unsigned noted;

    function new();
      fails   = 0;
      checked = 0;
      noted   = 0;
    endfunction

    static function int unsigned cum_days(logic [MONTH_W-1:0] m);
      case (m)
        4'd2:    return 31;
        4'd3:    return 59;
        4'd4:    return 90;
        4'd5:    return 120;
        4'd6:    return 151;
        4'd7:    return 181;
        4'd8:    return 212;
        4'd9:    return 243;
        4'd10:   return 273;
        4'd11:   return 304;
        4'd12:   return 334;
        4'd13:   return 365;
        4'd14:   return 395;
        4'd15:   return 425;
        default: return 0;
      endcase
    endfunction

    static function bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int unsigned day_index(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                                           logic [YEAR_W-1:0] y);
      int unsigned yy;
      int unsigned n;
      int unsigned p;
      yy = y;
      n  = DAYS_YEAR * yy;
      // leap years in 0..y-1, year 0 included
      if (yy > 0) begin
        p = yy - 1;
        n += p / 4 - p / 100 + p / 400 + 1;
      end
      n += cum_days(m);
      if (leap_year(yy) && m > 2) n++;
      return n + d;
    endfunction

    static function span_t predict(date_pair_t p);
      span_t       s;
      int unsigned n1;
      int unsigned n2;
      int unsigned diff;
      n1   = day_index(p.d1, p.m1, p.y1);
      n2   = day_index(p.d2, p.m2, p.y2);
      diff = (n1 >= n2) ? n1 - n2 : n2 - n1;
      if (diff > DAY_COUNT_MAX) diff = DAY_COUNT_MAX;
      s.days = diff[DAY_COUNT_W-1:0];
      if ({p.y1, p.m1, p.d1} == {p.y2, p.m2, p.d2}) s.order = ORDER_EQUAL;
      else if ({p.y1, p.m1, p.d1} > {p.y2, p.m2, p.d2}) s.order = ORDER_LATER;
      else s.order = ORDER_EARLIER;
      return s;
    endfunction

    function void note_dates(logic [IN_DATA_W-1:0] w);
      span_q.push_back(predict(date_pair_t'(w)));
      noted++;
    endfunction

    function int pending();
      return span_q.size();
    endfunction

    task report(string msg);
      if (fails < MAX_REPORTS) $display("mismatch: %s", msg);
      fails++;
    endtask

    task check_span(logic [OUT_DATA_W-1:0] w);
      span_t got;
      span_t want;
      got = span_t'(w);
      if (span_q.size() == 0) begin
        report($sformatf("output word %h with nothing expected", w));
        return;
      end
      want = span_q.pop_front();
      checked++;
      if (got.days !== want.days)
        report($sformatf("word %0d day_count %0d, expected %0d", checked, got.days, want.days));
      if (got.order !== want.order)
        report($sformatf("word %0d order_code %0d, expected %0d", checked, got.order,
                         want.order));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  bit          hold_req = 1'b0;
  bit          steady   = 1'b0;
  int unsigned directed_n;

  span_board board = new();

  date_day_difference_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int month_len(logic [MONTH_W-1:0] m, logic [YEAR_W-1:0] y);
    case (m)
      4'd2:                      return span_board::leap_year(y) ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11:   return 30;
      default:                   return 31;
    endcase
  endfunction

  function automatic logic [YEAR_W-1:0] pick_year();
    case ($urandom_range(0, 9))
      0:       return YEAR_W'(0);
      1:       return YEAR_W'(100 * $urandom_range(0, 99));
      2:       return YEAR_W'(400 * $urandom_range(0, 24));
      3:       return YEAR_W'(4 * $urandom_range(0, 2499));
      4:       return YEAR_W'(9999);
      5:       return {YEAR_W{1'b1}};
      6:       return YEAR_W'($urandom_range(10000, 16383));
      7:       return YEAR_W'($urandom_range(0, 3));
      default: return YEAR_W'($urandom_range(0, 9999));
    endcase
  endfunction

  function automatic date_pair_t make_pair(int d1, int m1, int y1, int d2, int m2, int y2);
    date_pair_t p;
    p.pad = '0;
    p.d1  = DAY_W'(d1);
    p.m1  = MONTH_W'(m1);
    p.y1  = YEAR_W'(y1);
    p.d2  = DAY_W'(d2);
    p.m2  = MONTH_W'(m2);
    p.y2  = YEAR_W'(y2);
    return p;
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t  p;
    int          kind;
    logic [63:0] raw;
    kind = $urandom_range(0, 99);
    p    = '0;
    if (kind < 60) begin
      // calendar dates, often in the same or a nearby year
      p.y1 = YEAR_W'($urandom_range(0, 9999));
      p.m1 = MONTH_W'($urandom_range(1, 12));
      p.d1 = DAY_W'($urandom_range(1, month_len(p.m1, p.y1)));
      if ($urandom_range(0, 2) == 0) p.y2 = p.y1 ^ YEAR_W'($urandom_range(0, 3));
      else p.y2 = YEAR_W'($urandom_range(0, 9999));
      p.m2 = MONTH_W'($urandom_range(1, 12));
      p.d2 = DAY_W'($urandom_range(1, month_len(p.m2, p.y2)));
    end else if (kind < 85) begin
      raw   = {$urandom, $urandom};
      p     = date_pair_t'(raw[IN_DATA_W-1:0]);
      p.pad = '0;
    end else begin
      raw  = {$urandom, $urandom};
      p.y1 = pick_year();
      p.y2 = pick_year();
      p.m1 = raw[MONTH_W-1:0];
      p.m2 = raw[2*MONTH_W-1:MONTH_W];
      p.d1 = raw[16+DAY_W-1:16];
      p.d2 = raw[24+DAY_W-1:24];
      if (raw[40]) begin
        p.y2 = p.y1;
        p.m2 = p.m1;
        if (raw[41]) p.d2 = p.d1;
      end
    end
    return p;
  endfunction

  task automatic send_dates(date_pair_t p, int gap);
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (board.pending() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_dates(s_tdata);
      if (m_tvalid && m_tready) board.check_span(m_tdata);
    end
  end

  initial begin
    int r;
    m_tready = 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (steady) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          m_tready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 95) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("** date_day_difference_core: FAILED **");
    $finish;
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_dates(make_pair(1, 1, 0, 1, 1, 0), pick_gap());
    send_dates(make_pair(31, 12, 9999, 1, 1, 0), pick_gap());
    send_dates(make_pair(1, 1, 0, 31, 12, 9999), pick_gap());
    send_dates(make_pair(29, 2, 2000, 1, 3, 2000), pick_gap());
    send_dates(make_pair(28, 2, 1900, 1, 3, 1900), pick_gap());
    send_dates(make_pair(29, 2, 0, 1, 3, 0), pick_gap());
    send_dates(make_pair(1, 1, 2024, 31, 12, 2023), pick_gap());
    send_dates(make_pair(0, 0, 0, 0, 0, 0), pick_gap());
    // saturation of day_count
    send_dates(make_pair(31, 15, 16383, 0, 0, 0), pick_gap());
    send_dates(make_pair(0, 0, 0, 31, 15, 16383), pick_gap());
    send_dates(make_pair(31, 15, 16383, 31, 15, 16383), pick_gap());
    // months past December and month zero
    send_dates(make_pair(1, 13, 2023, 1, 1, 2024), pick_gap());
    send_dates(make_pair(15, 14, 2000, 15, 15, 2000), pick_gap());
    send_dates(make_pair(1, 0, 1999, 1, 1, 1999), pick_gap());
    // stray days; order by fields disagrees with day numbers
    send_dates(make_pair(0, 3, 2021, 28, 2, 2021), pick_gap());
    send_dates(make_pair(31, 2, 2021, 1, 3, 2021), pick_gap());
    send_dates(make_pair(1, 1, 10000, 1, 1, 9999), pick_gap());
    send_dates(make_pair(1, 1, 1600, 1, 1, 1700), pick_gap());
    send_dates(make_pair(12, 10, 1582, 15, 10, 1582), pick_gap());
    send_dates(make_pair(31, 12, 1, 1, 1, 2), pick_gap());
    send_dates(make_pair(5, 7, 2023, 5, 6, 2023), pick_gap());
    send_dates(make_pair(10, 3, 2023, 9, 3, 2023), pick_gap());
    send_dates(make_pair(21, 10, 10922, 10, 5, 5461), pick_gap());
    send_dates(make_pair(10, 5, 5461, 21, 10, 10922), pick_gap());
    directed_n = 24;

    repeat (600) send_dates(random_pair(), pick_gap());

    // long output stall while words keep coming
    hold_req = 1'b1;
    repeat (60) send_dates(random_pair(), 0);
    s_tvalid <= 1'b0;
    wait_drained();

    steady = 1'b1;
    repeat (150) send_dates(random_pair(), 0);
    steady = 1'b0;

    repeat (740) send_dates(random_pair(), pick_gap());
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);

    $display("sent %0d directed and %0d random date pairs, checked %0d output words",
             directed_n, board.noted - directed_n, board.checked);
    $display("ran with random gaps, a long output stall, a full drain and a back-to-back run");
    if (board.fails == 0 && board.pending() == 0) begin
      $display("** date_day_difference_core: PASSED **");
    end else begin
      $display("** date_day_difference_core: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
src/ddd_pkg.sv
src/ddd_date_num.sv
src/ddd_diff.sv
src/date_day_difference_core.sv
dv/testbench.sv
